@@ rtl/mols_pkg.sv @@
// shared types, codes and defaults for the open-loop start-up sequencer
package mols_pkg;

    localparam int FREQ_W = 12;
    localparam int MOD_W  = 10;
    localparam int MS_W   = 16;
    localparam int LIM_W  = 13;
    localparam int SAMP_W = 12;
    localparam int CNT_W  = 4;
    localparam int ADV_W  = 32;
    localparam int NOW_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int RAMP_TIME_MS_DEF       = 1000;
    localparam int ENCODER_FAIL_LIMIT_DEF = 2;
    localparam int TIME_BITS_DEF          = 32;

    localparam logic [MS_W-1:0]   ALIGN_TIME_RST   = 16'd300;
    localparam logic [MS_W-1:0]   RUN_TIMEOUT_RST  = 16'd3000;
    localparam logic [MS_W-1:0]   MON_PERIOD_RST   = 16'd100;
    localparam logic [MOD_W-1:0]  ALIGN_MOD_RST    = 10'd50;
    localparam logic [MOD_W-1:0]  RUN_MOD_RST      = 10'd100;
    localparam logic [FREQ_W-1:0] START_FREQ_RST   = 12'd50;
    localparam logic [FREQ_W-1:0] TARGET_FREQ_RST  = 12'd200;
    localparam logic [LIM_W-1:0]  ADC_LIMIT_RST    = 13'd4090;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_READY    = 3'd1,
        MODE_ALIGN    = 3'd2,
        MODE_RUN      = 3'd3,
        MODE_STOPPING = 3'd4,
        MODE_FAULT    = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        FAULT_NONE    = 3'd0,
        FAULT_PWM     = 3'd1,
        FAULT_DRV     = 3'd2,
        FAULT_ADC     = 3'd3,
        FAULT_ENC     = 3'd4,
        FAULT_TIMEOUT = 3'd5
    } t_fault;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_REJ_FAULT = 2'd1,
        STATUS_REJ_STATE = 2'd2,
        STATUS_NONE      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FUNC_POLL  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALIGN_TIME  = 3'd0,
        REG_RUN_TIMEOUT = 3'd1,
        REG_MON_PERIOD  = 3'd2,
        REG_ALIGN_MOD   = 3'd3,
        REG_RUN_MOD     = 3'd4,
        REG_START_FREQ  = 3'd5,
        REG_TARGET_FREQ = 3'd6,
        REG_ADC_LIMIT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]        func;
        logic [NOW_W-1:0]  now_ms;
        logic              adc_read_ok;
        logic [SAMP_W-1:0] phase_u_sample;
        logic [SAMP_W-1:0] phase_v_sample;
        logic              encoder_ok;
        logic              pwm_start_ok;
        logic              pwm_set_ok;
        logic              driver_enable_ok;
    } t_cmd;

    typedef struct packed {
        t_mode            mode;
        t_fault           fault_code;
        t_status          command_status;
        logic             advance_valid;
        logic [ADV_W-1:0] advance_ms;
        logic             pwm_update_valid;
        logic [MOD_W-1:0] mod_depth;
        logic             drive_enable;
        logic             pwm_enable;
    } t_res;

endpackage

@@ rtl/mols_cmd_if.sv @@
// command channel: valid/ready handshake with the poll and command payload
interface mols_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic        adc_read_ok;
    logic [11:0] phase_u_sample;
    logic [11:0] phase_v_sample;
    logic        encoder_ok;
    logic        pwm_start_ok;
    logic        pwm_set_ok;
    logic        driver_enable_ok;

    modport source (
        output valid, func, now_ms, adc_read_ok, phase_u_sample, phase_v_sample,
               encoder_ok, pwm_start_ok, pwm_set_ok, driver_enable_ok,
        input  ready
    );

    modport sink (
        input  valid, func, now_ms, adc_read_ok, phase_u_sample, phase_v_sample,
               encoder_ok, pwm_start_ok, pwm_set_ok, driver_enable_ok,
        output ready
    );
endinterface

@@ rtl/mols_res_if.sv @@
// result channel: valid/ready handshake with the sequencer result payload
interface mols_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [2:0]  fault_code;
    logic [1:0]  command_status;
    logic        advance_valid;
    logic [31:0] advance_ms;
    logic [11:0] frequency_x10;
    logic        pwm_update_valid;
    logic [9:0]  mod_depth;
    logic        drive_enable;
    logic        pwm_enable;

    modport source (
        output valid, mode, fault_code, command_status, advance_valid, advance_ms,
               frequency_x10, pwm_update_valid, mod_depth, drive_enable,
               pwm_enable,
        input  ready
    );

    modport sink (
        input  valid, mode, fault_code, command_status, advance_valid, advance_ms,
               frequency_x10, pwm_update_valid, mod_depth, drive_enable,
               pwm_enable,
        output ready
    );
endinterface

@@ rtl/motor_open_loop_startup_fsm.sv @@
// top level: open-loop motor start-up sequencer with registered result pipeline
// a command's result is registered in stages a, b and c, then in the output register
// one command per cycle unless stalled; the ramp divide runs over three pipeline stages
// stalls: all stages hold together while a finished result waits on the output
// reset: synchronous active low; sequencer state cleared, configuration to defaults
// pipeline valids cleared at reset; no clearing pass, commands taken right after reset
module motor_open_loop_startup_fsm #(
    parameter int RAMP_TIME_MS       = mols_pkg::RAMP_TIME_MS_DEF,
    parameter int ENCODER_FAIL_LIMIT = mols_pkg::ENCODER_FAIL_LIMIT_DEF,
    parameter int TIME_BITS          = mols_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mols_cmd_if.sink                         i_cmd,
    mols_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [mols_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mols_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mols_pkg::*;

    logic                 en, accept;
    t_cmd                 cmd;
    t_res                 c_res;
    logic [TIME_BITS-1:0] c_elapsed;
    logic [FREQ_W-1:0]    c_start_freq, c_target_freq;
    logic [FREQ_W-1:0]    ramp_freq;

    logic              r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    t_res              r_a_res, r_b_res, r_c_res, r_out_res;
    logic [FREQ_W-1:0] r_out_freq;

    assign en          = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && en;
    assign i_cmd.ready = en;

    assign cmd.func             = i_cmd.func;
    assign cmd.now_ms           = i_cmd.now_ms;
    assign cmd.adc_read_ok      = i_cmd.adc_read_ok;
    assign cmd.phase_u_sample   = i_cmd.phase_u_sample;
    assign cmd.phase_v_sample   = i_cmd.phase_v_sample;
    assign cmd.encoder_ok       = i_cmd.encoder_ok;
    assign cmd.pwm_start_ok     = i_cmd.pwm_start_ok;
    assign cmd.pwm_set_ok       = i_cmd.pwm_set_ok;
    assign cmd.driver_enable_ok = i_cmd.driver_enable_ok;

    mols_ctrl #(
        .ENCODER_FAIL_LIMIT (ENCODER_FAIL_LIMIT),
        .TIME_BITS          (TIME_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_res         (c_res),
        .o_elapsed     (c_elapsed),
        .o_start_freq  (c_start_freq),
        .o_target_freq (c_target_freq)
    );

    mols_ramp #(
        .RAMP_TIME_MS (RAMP_TIME_MS),
        .TIME_BITS    (TIME_BITS)
    ) u_ramp (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_elapsed     (c_elapsed),
        .i_start_freq  (c_start_freq),
        .i_target_freq (c_target_freq),
        .o_freq        (ramp_freq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= accept;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_res    <= c_res;
            r_b_res    <= r_a_res;
            r_c_res    <= r_b_res;
            r_out_res  <= r_c_res;
            r_out_freq <= r_c_res.advance_valid ? ramp_freq : '0;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.mode             = r_out_res.mode;
    assign o_res.fault_code       = r_out_res.fault_code;
    assign o_res.command_status   = r_out_res.command_status;
    assign o_res.advance_valid    = r_out_res.advance_valid;
    assign o_res.advance_ms       = r_out_res.advance_ms;
    assign o_res.frequency_x10    = r_out_freq;
    assign o_res.pwm_update_valid = r_out_res.pwm_update_valid;
    assign o_res.mod_depth        = r_out_res.mod_depth;
    assign o_res.drive_enable     = r_out_res.drive_enable;
    assign o_res.pwm_enable       = r_out_res.pwm_enable;

    // fault mode and a latched fault code go together
    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.mode == MODE_FAULT) == (o_res.fault_code != FAULT_NONE)))
        else $error("fault code does not match fault mode");

    a_drive_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.drive_enable |-> o_res.pwm_enable)
        else $error("drive enabled without pwm");

    a_adv_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.advance_valid |-> o_res.advance_ms != '0)
        else $error("angle advance with zero elapsed time");

    a_adv_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.advance_valid |-> o_res.pwm_update_valid
            && (o_res.mode == MODE_RUN || o_res.mode == MODE_FAULT))
        else $error("angle advance outside run");

endmodule

@@ rtl/mols_ctrl.sv @@
// sequencer state, configuration registers and single-pass command decode
module mols_ctrl #(
    parameter int ENCODER_FAIL_LIMIT = mols_pkg::ENCODER_FAIL_LIMIT_DEF,
    parameter int TIME_BITS          = mols_pkg::TIME_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  mols_pkg::t_cmd                         i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [mols_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mols_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output mols_pkg::t_res                         o_res,
    output logic [TIME_BITS-1:0]                   o_elapsed,
    output logic [mols_pkg::FREQ_W-1:0]            o_start_freq,
    output logic [mols_pkg::FREQ_W-1:0]            o_target_freq
);
    import mols_pkg::*;

    localparam logic [CNT_W-1:0] ENC_LIMIT = CNT_W'(ENCODER_FAIL_LIMIT);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef struct packed {
        logic             fault;
        t_fault           code;
        logic [CNT_W-1:0] cnt;
    } t_chk;

    // configuration
    logic [MS_W-1:0]   r_align_time, r_run_timeout, r_mon_period;
    logic [MOD_W-1:0]  r_align_mod, r_run_mod;
    logic [FREQ_W-1:0] r_start_freq, r_target_freq;
    logic [LIM_W-1:0]  r_adc_limit;

    // sequencer state
    t_mode                r_mode, n_mode;
    t_fault               r_fault, n_fault;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_step, n_step;
    logic [TIME_BITS-1:0] r_mon, n_mon;
    logic [CNT_W-1:0]     r_enc_cnt, n_enc_cnt;
    logic                 r_drive, n_drive;
    logic                 r_pwm, n_pwm;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_start, since_step, since_mon;
    logic                 align_done, run_timeout, step_due, mon_due;
    t_func                func;
    t_chk                 chk1, chk2;
    logic [CNT_W-1:0]     mon_cnt_in;
    logic                 mon_en;
    logic                 f_take;
    t_fault               f_code;

    t_status              c_status;
    logic                 c_adv, c_upd;
    logic [MOD_W-1:0]     c_mod;

    function automatic t_chk check_inputs(input t_cmd c, input logic [LIM_W-1:0] lim,
                                          input logic [CNT_W-1:0] cnt);
        t_chk r;
        r.fault = 1'b0;
        r.code  = FAULT_NONE;
        r.cnt   = cnt;
        if (!c.adc_read_ok || LIM_W'(c.phase_u_sample) >= lim
                || LIM_W'(c.phase_v_sample) >= lim) begin
            r.fault = 1'b1;
            r.code  = FAULT_ADC;
        end else if (c.encoder_ok) begin
            r.cnt = '0;
        end else begin
            if (cnt != CNT_MAX) begin
                r.cnt = cnt + CNT_W'(1);
            end
            if (r.cnt >= ENC_LIMIT) begin
                r.fault = 1'b1;
                r.code  = FAULT_ENC;
            end
        end
        return r;
    endfunction

    assign func        = t_func'(i_cmd.func);
    assign now         = i_cmd.now_ms[TIME_BITS-1:0];
    assign since_start = now - r_start;
    assign since_step  = now - r_step;
    assign since_mon   = now - r_mon;
    assign align_done  = since_start >= TIME_BITS'(r_align_time);
    assign run_timeout = since_start >= TIME_BITS'(r_run_timeout);
    assign step_due    = since_step != '0;
    assign mon_due     = since_mon >= TIME_BITS'(r_mon_period);

    // a start-up poll may run the periodic check a second time on the same samples
    assign chk1       = check_inputs(i_cmd, r_adc_limit, r_enc_cnt);
    assign mon_cnt_in = (r_mode == MODE_READY) ? chk1.cnt : r_enc_cnt;
    assign chk2       = check_inputs(i_cmd, r_adc_limit, mon_cnt_in);

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_fault   = r_fault;
        n_start   = r_start;
        n_step    = r_step;
        n_mon     = r_mon;
        n_enc_cnt = r_enc_cnt;
        n_drive   = r_drive;
        n_pwm     = r_pwm;
        mon_en    = 1'b0;
        f_take    = 1'b0;
        f_code    = FAULT_NONE;
        case (func)
            FUNC_START: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode  = MODE_READY;
                    n_start = now;
                end
            end
            FUNC_STOP: begin
                if (r_mode != MODE_IDLE && r_mode != MODE_FAULT) begin
                    n_mode = MODE_STOPPING;
                end
            end
            FUNC_CLEAR: begin
                if (r_mode == MODE_FAULT) begin
                    n_drive = 1'b0;
                    n_pwm   = 1'b0;
                    n_fault = FAULT_NONE;
                    n_mode  = MODE_IDLE;
                    n_start = now;
                end
            end
            FUNC_POLL: begin
                case (r_mode)
                    MODE_READY: begin
                        n_enc_cnt = chk1.cnt;
                        if (chk1.fault) begin
                            f_take = 1'b1;
                            f_code = chk1.code;
                        end else if (!i_cmd.pwm_start_ok || !i_cmd.pwm_set_ok) begin
                            f_take = 1'b1;
                            f_code = FAULT_PWM;
                        end else if (!i_cmd.driver_enable_ok) begin
                            f_take = 1'b1;
                            f_code = FAULT_DRV;
                        end else begin
                            n_drive = 1'b1;
                            n_pwm   = 1'b1;
                            n_mode  = MODE_ALIGN;
                            n_start = now;
                            n_step  = now;
                            n_mon   = now;
                            mon_en  = (r_mon_period == '0);
                        end
                    end
                    MODE_ALIGN: begin
                        if (align_done) begin
                            n_mode  = MODE_RUN;
                            n_start = now;
                            n_step  = now;
                        end
                        mon_en = mon_due;
                    end
                    MODE_RUN: begin
                        if (run_timeout) begin
                            f_take = 1'b1;
                            f_code = FAULT_TIMEOUT;
                        end else if (step_due && !i_cmd.pwm_set_ok) begin
                            f_take = 1'b1;
                            f_code = FAULT_PWM;
                        end else begin
                            if (step_due) begin
                                n_step = now;
                            end
                            mon_en = mon_due;
                        end
                    end
                    MODE_STOPPING: begin
                        n_drive = 1'b0;
                        n_pwm   = 1'b0;
                        n_mode  = MODE_IDLE;
                        n_start = now;
                    end
                    default: begin
                    end
                endcase
                if (mon_en) begin
                    n_mon     = now;
                    n_enc_cnt = chk2.cnt;
                    if (chk2.fault) begin
                        f_take = 1'b1;
                        f_code = chk2.code;
                    end
                end
                if (f_take) begin
                    n_mode  = MODE_FAULT;
                    n_fault = f_code;
                    n_drive = 1'b0;
                    n_pwm   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // per-item outputs
    always_comb begin
        c_status = STATUS_NONE;
        c_adv    = 1'b0;
        c_upd    = 1'b0;
        c_mod    = '0;
        case (func)
            FUNC_START: begin
                if (r_mode == MODE_FAULT) begin
                    c_status = STATUS_REJ_FAULT;
                end else if (r_mode != MODE_IDLE) begin
                    c_status = STATUS_REJ_STATE;
                end else begin
                    c_status = STATUS_ACCEPTED;
                end
            end
            FUNC_STOP: begin
                if (r_mode == MODE_FAULT) begin
                    c_status = STATUS_REJ_FAULT;
                end else if (r_mode == MODE_IDLE) begin
                    c_status = STATUS_REJ_STATE;
                end else begin
                    c_status = STATUS_ACCEPTED;
                end
            end
            FUNC_CLEAR: begin
                if (r_mode != MODE_FAULT) begin
                    c_status = STATUS_REJ_STATE;
                end else begin
                    c_status = STATUS_ACCEPTED;
                end
            end
            FUNC_POLL: begin
                if (r_mode == MODE_READY && !chk1.fault && i_cmd.pwm_start_ok) begin
                    c_upd = 1'b1;
                    c_mod = r_align_mod;
                end
                if (r_mode == MODE_RUN && !run_timeout && step_due) begin
                    c_adv = 1'b1;
                    c_upd = 1'b1;
                    c_mod = r_run_mod;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.mode             = n_mode;
    assign o_res.fault_code       = n_fault;
    assign o_res.command_status   = c_status;
    assign o_res.advance_valid    = c_adv;
    assign o_res.advance_ms       = c_adv ? ADV_W'(since_step) : '0;
    assign o_res.pwm_update_valid = c_upd;
    assign o_res.mod_depth        = c_mod;
    assign o_res.drive_enable     = n_drive;
    assign o_res.pwm_enable       = n_pwm;

    assign o_elapsed     = since_start;
    assign o_start_freq  = r_start_freq;
    assign o_target_freq = r_target_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_fault   <= FAULT_NONE;
            r_start   <= '0;
            r_step    <= '0;
            r_mon     <= '0;
            r_enc_cnt <= '0;
            r_drive   <= 1'b0;
            r_pwm     <= 1'b0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_fault   <= n_fault;
            r_start   <= n_start;
            r_step    <= n_step;
            r_mon     <= n_mon;
            r_enc_cnt <= n_enc_cnt;
            r_drive   <= n_drive;
            r_pwm     <= n_pwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_time  <= ALIGN_TIME_RST;
            r_run_timeout <= RUN_TIMEOUT_RST;
            r_mon_period  <= MON_PERIOD_RST;
            r_align_mod   <= ALIGN_MOD_RST;
            r_run_mod     <= RUN_MOD_RST;
            r_start_freq  <= START_FREQ_RST;
            r_target_freq <= TARGET_FREQ_RST;
            r_adc_limit   <= ADC_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ALIGN_TIME:  r_align_time  <= i_cfg_data[MS_W-1:0];
                REG_RUN_TIMEOUT: r_run_timeout <= i_cfg_data[MS_W-1:0];
                REG_MON_PERIOD:  r_mon_period  <= i_cfg_data[MS_W-1:0];
                REG_ALIGN_MOD:   r_align_mod   <= i_cfg_data[MOD_W-1:0];
                REG_RUN_MOD:     r_run_mod     <= i_cfg_data[MOD_W-1:0];
                REG_START_FREQ:  r_start_freq  <= i_cfg_data[FREQ_W-1:0];
                REG_TARGET_FREQ: r_target_freq <= i_cfg_data[FREQ_W-1:0];
                REG_ADC_LIMIT:   r_adc_limit   <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/mols_ramp.sv @@
// three-stage linear frequency ramp with reciprocal-multiply divide
module mols_ramp #(
    parameter int RAMP_TIME_MS = mols_pkg::RAMP_TIME_MS_DEF,
    parameter int TIME_BITS    = mols_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [TIME_BITS-1:0]         i_elapsed,
    input  logic [mols_pkg::FREQ_W-1:0]  i_start_freq,
    input  logic [mols_pkg::FREQ_W-1:0]  i_target_freq,
    output logic [mols_pkg::FREQ_W-1:0]  o_freq
);
    import mols_pkg::*;

    localparam int EL_W    = $clog2(RAMP_TIME_MS + 1);
    localparam int PROD_W  = FREQ_W + EL_W;
    localparam int SHIFT   = PROD_W + $clog2(RAMP_TIME_MS);
    localparam int RECIP_W = PROD_W + 2;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << SHIFT) + longint'(RAMP_TIME_MS) - 1) / longint'(RAMP_TIME_MS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // stage a: operands
    logic              r_a_full, r_a_down;
    logic [EL_W-1:0]   r_a_el;
    logic [FREQ_W-1:0] r_a_s, r_a_t;
    // stage b: span times elapsed
    logic              r_b_full, r_b_down;
    logic [PROD_W-1:0] r_b_prod;
    logic [FREQ_W-1:0] r_b_s, r_b_t;
    // stage c: quotient
    logic              r_c_full, r_c_down;
    logic [FREQ_W-1:0] r_c_q;
    logic [FREQ_W-1:0] r_c_s, r_c_t;

    logic [FREQ_W-1:0] span;
    logic [MUL_W-1:0]  mul_q;

    assign span  = r_a_down ? (r_a_s - r_a_t) : (r_a_t - r_a_s);
    assign mul_q = MUL_W'(r_b_prod) * MUL_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_full <= i_elapsed >= TIME_BITS'(RAMP_TIME_MS);
            r_a_down <= i_target_freq < i_start_freq;
            r_a_el   <= i_elapsed[EL_W-1:0];
            r_a_s    <= i_start_freq;
            r_a_t    <= i_target_freq;

            r_b_full <= r_a_full;
            r_b_down <= r_a_down;
            r_b_prod <= PROD_W'(span) * PROD_W'(r_a_el);
            r_b_s    <= r_a_s;
            r_b_t    <= r_a_t;

            r_c_full <= r_b_full;
            r_c_down <= r_b_down;
            r_c_q    <= mul_q[SHIFT +: FREQ_W];
            r_c_s    <= r_b_s;
            r_c_t    <= r_b_t;
        end
    end

    assign o_freq = r_c_full ? r_c_t : (r_c_down ? (r_c_s - r_c_q) : (r_c_s + r_c_q));

endmodule
